// ===== design/radix_string_converter_unit_macros.svh =====
// Assertion macros for the radix string converter.
// Every property is clocked on clk_i and disabled while rst_ni is low.
`ifndef RADIX_STRING_CONVERTER_UNIT_MACROS_SVH
`define RADIX_STRING_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define RSC_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) trig |=> cons) \
    else $error(msg);
`else
`define RSC_ASSERT(name, prop, msg)
`define RSC_ASSERT_NEXT(name, trig, cons, msg)
`endif

`endif

// ===== design/rsc_pkg.sv =====
`timescale 1ns / 1ps
package rsc_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned BASE_W     = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int unsigned SP_W       = $clog2(MAX_DIGITS + 1);
  localparam int unsigned PC_W       = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_A    = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_F    = 8'd70;
  localparam logic [CHAR_W-1:0] DEC_TEN    = 8'd10;

  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
  localparam logic [BASE_W-1:0] NO_DIGIT   = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BASE = 2'd1;

  // Datapath operation of one microcode step.
  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_TAKE = 3'd1,
    OP_DIV  = 3'd2,
    OP_PUSH = 3'd3,
    OP_POP  = 3'd4
  } op_e;

  // Jump condition; the jump is taken when it is true, else pc + 1.
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_NO_EMIT  = 3'd1,
    C_BIT_LEFT = 3'd2,
    C_MORE     = 3'd3,
    C_NOT_LAST = 3'd4
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  typedef struct packed {
    logic emit_now;
    logic bit_left;
    logic more;
    logic pop_last;
  } status_t;

  localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
  localparam logic [PC_W-1:0] PC_DIV  = 3'd1;
  localparam logic [PC_W-1:0] PC_PUSH = 3'd2;
  localparam logic [PC_W-1:0] PC_POP  = 3'd3;
  localparam logic [PC_W-1:0] PC_RET  = 3'd4;

  // Microcode ROM.
  function automatic ctrl_word_t prog_word(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      PC_IDLE: w = '{op: OP_TAKE, cond: C_NO_EMIT,  target: PC_IDLE};
      PC_DIV:  w = '{op: OP_DIV,  cond: C_BIT_LEFT, target: PC_DIV};
      PC_PUSH: w = '{op: OP_PUSH, cond: C_MORE,     target: PC_DIV};
      PC_POP:  w = '{op: OP_POP,  cond: C_NOT_LAST, target: PC_POP};
      PC_RET:  w = '{op: OP_NOP,  cond: C_ALWAYS,   target: PC_IDLE};
      default: w = '{op: OP_NOP,  cond: C_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    else r = b;
    return r;
  endfunction

  // Digit value of a character, NO_DIGIT for anything else.
  function automatic logic [BASE_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    t = '0;
    if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
      t = c - ASCII_ZERO;
    end else if (c >= ASCII_A && c <= ASCII_F) begin
      t = c - ASCII_A + DEC_TEN;
    end else begin
      t = {3'b000, NO_DIGIT};
    end
    return t[BASE_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] x;
    x = {4'b0000, d};
    return (x < DEC_TEN) ? (ASCII_ZERO + x) : (ASCII_A + x - DEC_TEN);
  endfunction

endpackage

// ===== design/radix_string_converter_unit.sv =====
`timescale 1ns / 1ps
// Radix string converter. Characters arrive one per transfer, most significant
// digit first, in input_base (config index 0); only '0'-'9' and 'A'-'F' below
// that base count as digits. Each digit is folded in as value*base + digit in
// the same cycle it is taken, so a character that does not end a number does
// not stall the input. Outside a dropped stretch, a character marked final or
// an invalid character starts emission: the value is written out in
// output_base (config index 1) as ASCII digits, most significant first,
// end_of_number on the last one. An invalid character emits the partial
// value with bad_digit set and, unless it is itself marked final, drops the
// following characters up to and including the next final mark. overflowed
// is set on every digit of a number whose value went past WIDTH bits (low
// WIDTH bits are kept). Bases below 2 act as 2, above 16 as 16. At most 32
// digits, the least significant ones, are emitted. Emission: a bit-serial
// divider gives one quotient bit per cycle, so each digit takes WIDTH divide
// steps plus a push onto the digit stack, the stack is then unloaded one digit
// per cycle while the output is not stalled, and one last step returns to
// idle. No character is taken during emission; the final output digit may
// still sit in the output register while the next character is taken.
// Configuration is always ready and must only be written while the block is
// idle.
module radix_string_converter_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rsc_pkg::BASE_W-1:0]        cfg_data_i,
  // character input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rsc_pkg::CHAR_W-1:0]        digit_char_i,
  input  logic                              final_char_i,
  // digit output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rsc_pkg::CHAR_W-1:0]        out_char_o,
  output logic                              end_of_number_o,
  output logic                              bad_digit_o,
  output logic                              overflowed_o
);
  import rsc_pkg::*;

  logic [BASE_W-1:0] in_base_q, out_base_q;
  logic [BASE_W-1:0] in_base_c, out_base_c;
  ctrl_word_t        ctrl;
  status_t           status;

  assign cfg_ready_o = 1'b1;

  // raw register values are kept; clamping happens on the way to the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_base_q  <= BASE_RESET;
      out_base_q <= BASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_INPUT_BASE:  in_base_q  <= cfg_data_i;
        CFG_OUTPUT_BASE: out_base_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_base_c  = clamp_base(in_base_q);
  assign out_base_c = clamp_base(out_base_q);

  // microcode sequencer: step counter, control ROM, conditional jumps
  rsc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // accumulator, bit-serial divider, digit stack and output register
  rsc_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .in_base_i       (in_base_c),
    .out_base_i      (out_base_c),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .digit_char_i    (digit_char_i),
    .final_char_i    (final_char_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .end_of_number_o (end_of_number_o),
    .bad_digit_o     (bad_digit_o),
    .overflowed_o    (overflowed_o)
  );

endmodule

// ===== design/rsc_seq.sv =====
`timescale 1ns / 1ps
module rsc_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsc_pkg::status_t     status_i,
  output rsc_pkg::ctrl_word_t  ctrl_o
);
  import rsc_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      word;
  logic            jump;

  assign word   = prog_word(pc_q);
  assign ctrl_o = word;

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:   jump = 1'b1;
      C_NO_EMIT:  jump = !status_i.emit_now;
      C_BIT_LEFT: jump = status_i.bit_left;
      C_MORE:     jump = status_i.more;
      C_NOT_LAST: jump = !status_i.pop_last;
      default:    jump = 1'b1;
    endcase
    pc_d = jump ? word.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== design/rsc_datapath.sv =====
`timescale 1ns / 1ps
`include "radix_string_converter_unit_macros.svh"
module rsc_datapath #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsc_pkg::ctrl_word_t           ctrl_i,
  output rsc_pkg::status_t              status_o,
  input  logic [rsc_pkg::BASE_W-1:0]    in_base_i,
  input  logic [rsc_pkg::BASE_W-1:0]    out_base_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rsc_pkg::CHAR_W-1:0]    digit_char_i,
  input  logic                          final_char_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rsc_pkg::CHAR_W-1:0]    out_char_o,
  output logic                          end_of_number_o,
  output logic                          bad_digit_o,
  output logic                          overflowed_o
);
  import rsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam int unsigned PROD_W = WIDTH + BASE_W;
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(WIDTH - 1);

  // number being accumulated
  logic [WIDTH-1:0]   acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic               drop_q, drop_d;
  // value being emitted and its flags
  logic [WIDTH-1:0]   dv_q, dv_d;
  logic               err_q, err_d;
  logic               eovf_q, eovf_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SP_W-1:0]    sp_q, sp_d;
  logic [DIGIT_W-1:0] stack_q [MAX_DIGITS];
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_end_q, out_bad_q, out_ovf_q;

  logic               in_fire;
  logic [BASE_W-1:0]  dval;
  logic               bad;
  logic [PROD_W-1:0]  sum;
  logic               ovf_now;
  logic [BASE_W-1:0]  r2;
  logic               ge;
  logic               slot_free, pop_fire;
  logic [SP_W-1:0]    sp_m1;
  logic [DIGIT_W-1:0] top_digit;

  assign in_stall_o = (ctrl_i.op != OP_TAKE);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign dval    = char_value(digit_char_i);
  assign bad     = (dval >= in_base_i);
  assign sum     = PROD_W'(acc_q) * PROD_W'(in_base_i) + PROD_W'(dval);
  assign ovf_now = |sum[PROD_W-1:WIDTH];

  assign r2 = {rem_q, dv_q[WIDTH-1]};
  assign ge = (r2 >= out_base_i);

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_fire  = (ctrl_i.op == OP_POP) && slot_free;
  assign sp_m1     = sp_q - 1'b1;
  assign top_digit = stack_q[sp_m1[DIG_IDX_W-1:0]];

  assign status_o.emit_now = in_fire && !drop_q && (bad || final_char_i);
  assign status_o.bit_left = (cnt_q != '0);
  assign status_o.more     = (dv_q != '0) && (sp_q < SP_W'(MAX_DIGITS - 1));
  assign status_o.pop_last = pop_fire && (sp_q == SP_W'(1));

  always_comb begin
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    drop_d      = drop_q;
    dv_d        = dv_q;
    err_d       = err_q;
    eovf_d      = eovf_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    sp_d        = sp_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (ctrl_i.op)
      OP_TAKE: begin
        if (in_fire) begin
          if (drop_q) begin
            if (final_char_i) drop_d = 1'b0;
          end else if (bad || final_char_i) begin
            // number ends here: hand it to the divider, clear the accumulator
            dv_d   = bad ? acc_q : sum[WIDTH-1:0];
            err_d  = bad;
            eovf_d = bad ? ovf_q : (ovf_q || ovf_now);
            drop_d = bad && !final_char_i;
            acc_d  = '0;
            ovf_d  = 1'b0;
            rem_d  = '0;
            cnt_d  = CNT_INIT;
            sp_d   = '0;
          end else begin
            acc_d = sum[WIDTH-1:0];
            ovf_d = ovf_q || ovf_now;
          end
        end
      end
      OP_DIV: begin
        // restoring division, one quotient bit per step
        rem_d = ge ? DIGIT_W'(r2 - out_base_i) : DIGIT_W'(r2);
        dv_d  = {dv_q[WIDTH-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end
      OP_PUSH: begin
        sp_d  = sp_q + 1'b1;
        rem_d = '0;
        cnt_d = CNT_INIT;
      end
      OP_POP: begin
        if (pop_fire) begin
          sp_d        = sp_m1;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      drop_q      <= 1'b0;
      err_q       <= 1'b0;
      eovf_q      <= 1'b0;
      rem_q       <= '0;
      cnt_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      drop_q      <= drop_d;
      err_q       <= err_d;
      eovf_q      <= eovf_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
    if (ctrl_i.op == OP_PUSH) begin
      stack_q[sp_q[DIG_IDX_W-1:0]] <= rem_q;
    end
    if (pop_fire) begin
      out_char_q <= digit_ascii(top_digit);
      out_end_q  <= (sp_q == SP_W'(1));
      out_bad_q  <= err_q;
      out_ovf_q  <= eovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign end_of_number_o = out_end_q;
  assign bad_digit_o     = out_bad_q;
  assign overflowed_o    = out_ovf_q;

  `RSC_ASSERT(a_sp_range, sp_q <= SP_W'(MAX_DIGITS), "digit stack pointer out of range")
  `RSC_ASSERT(a_pop_nonempty, (ctrl_i.op == OP_POP) |-> (sp_q != '0), "pop from empty stack")
  `RSC_ASSERT(a_rem_below_base, (ctrl_i.op == OP_DIV) |-> ({1'b0, rem_q} < out_base_i), "remainder not below output base")
  `RSC_ASSERT_NEXT(a_last_empties, status_o.pop_last, (sp_q == '0) && out_end_q, "last digit left stack nonempty")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for radix_string_converter_unit.
// Characters go in through a valid/stall port. Each accepted character runs
// through a local converter model that has its own copies of the radices, the
// accumulator and the drop/flag state. Every digit that the model expects goes
// into a queue. A monitor pops that queue on each output transfer and compares
// all four output fields.
module tb_top;
  import rsc_pkg::*;

  localparam int unsigned CONV_WIDTH    = 32;
  localparam int unsigned WIDE_W        = CONV_WIDTH + BASE_W;
  localparam int unsigned NOT_A_DIGIT   = 16;
  // Idle time after the last digit, before a radix write or the final verdict.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES   = 200;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SWEEP_PHASES  = 8;
  localparam int unsigned PHASE_CHARS   = 28;

  // Radix pairs for the random phases. Entry 0 is the rightmost one. The last
  // phase picks its radices at random.
  localparam logic [SWEEP_PHASES-1:0][BASE_W-1:0] IN_SWEEP =
    {5'd10, 5'd10, 5'd17, 5'd1, 5'd2, 5'd16, 5'd31, 5'd0};
  localparam logic [SWEEP_PHASES-1:0][BASE_W-1:0] OUT_SWEEP =
    {5'd10, 5'd10, 5'd17, 5'd0, 5'd16, 5'd2, 5'd1, 5'd31};

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eon;
    logic              bad;
    logic              ovf;
  } out_digit_t;

  // All DUT inputs are known from time zero.
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = CFG_INPUT_BASE;
  logic [BASE_W-1:0]    cfg_data_i   = BASE_RESET;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [CHAR_W-1:0]    digit_char_i = ASCII_ZERO;
  logic                 final_char_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [CHAR_W-1:0]    out_char_o;
  logic                 end_of_number_o;
  logic                 bad_digit_o;
  logic                 overflowed_o;

  always #1 clk_i = ~clk_i;

  radix_string_converter_unit #(
    .WIDTH (CONV_WIDTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .digit_char_i    (digit_char_i),
    .final_char_i    (final_char_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .end_of_number_o (end_of_number_o),
    .bad_digit_o     (bad_digit_o),
    .overflowed_o    (overflowed_o)
  );

  // ---------------------------------------------------------------------------
  // Converter model state. It mirrors the reset values of the block.
  // ---------------------------------------------------------------------------
  logic [BASE_W-1:0]     in_radix_reg  = BASE_RESET;
  logic [BASE_W-1:0]     out_radix_reg = BASE_RESET;
  logic [CONV_WIDTH-1:0] acc_value     = '0;
  logic                  dropping      = 1'b0;  // skipping up to the next final mark
  logic                  bad_pending   = 1'b0;
  logic                  ovf_pending   = 1'b0;
  logic [5:0]            digits_taken  = '0;    // saturating count of digits
  out_digit_t            pending_digits[$];

  // Traffic shaping: gap and stall chances in percent per cycle, and a receiver hold.
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_hold_req    = 0;
  int unsigned rx_hold_left   = 0;

  int unsigned chars_taken     = 0;
  int unsigned digits_checked  = 0;
  int unsigned numbers_checked = 0;
  int unsigned bad_numbers     = 0;
  int unsigned ovf_numbers     = 0;
  int unsigned fail_count      = 0;

  function automatic logic [BASE_W-1:0] clamp_radix(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  // Returns NOT_A_DIGIT for anything outside '0'-'9' and 'A'-'F'.
  function automatic int unsigned digit_weight(input logic [CHAR_W-1:0] c);
    if (c >= ASCII_ZERO && c <= ASCII_NINE) return 32'(c - ASCII_ZERO);
    if (c >= ASCII_A && c <= ASCII_F) return 32'(c - ASCII_A + DEC_TEN);
    return NOT_A_DIGIT;
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input int unsigned d);
    return (d < DEC_TEN) ? CHAR_W'(ASCII_ZERO + d) : CHAR_W'(ASCII_A + d - DEC_TEN);
  endfunction

  // Digits needed to print an all-ones accumulator in this radix.
  function automatic int unsigned full_length(input int unsigned radix);
    logic [CONV_WIDTH-1:0] v;
    int unsigned n;
    v = '1;
    n = 0;
    while (v != 0) begin
      v = v / radix;
      n++;
    end
    return n;
  endfunction

  // Queues the accumulator as output digits, most significant first, and then
  // clears the number. Only the low MAX_DIGITS digits are kept.
  function automatic void emit_number();
    int unsigned radix;
    logic [CONV_WIDTH-1:0] v;
    int unsigned digs[$];
    out_digit_t r;
    radix = 32'(clamp_radix(out_radix_reg));
    v = acc_value;
    do begin
      digs.push_front(v % radix);
      v = v / radix;
    end while (v != 0 && digs.size() < MAX_DIGITS);
    foreach (digs[k]) begin
      r.ch  = ascii_of(digs[k]);
      r.eon = (k == digs.size() - 1);
      r.bad = bad_pending;
      r.ovf = ovf_pending;
      pending_digits.push_back(r);
    end
    acc_value    = '0;
    bad_pending  = 1'b0;
    ovf_pending  = 1'b0;
    digits_taken = '0;
  endfunction

  // Applies one accepted character. Returns 0 if the character was dropped.
  function automatic bit convert_char(input logic [CHAR_W-1:0] c, input logic fin);
    int unsigned radix;
    int unsigned d;
    logic [WIDE_W-1:0] wide;
    radix = 32'(clamp_radix(in_radix_reg));
    d = digit_weight(c);
    if (dropping) begin
      if (fin) dropping = 1'b0;
      return 1'b0;
    end
    if (d >= radix) begin
      // Invalid character: the partial value goes out flagged.
      bad_pending = 1'b1;
      emit_number();
      dropping = !fin;
      return 1'b1;
    end
    wide = WIDE_W'(acc_value) * WIDE_W'(radix) + WIDE_W'(d);
    if (wide[CONV_WIDTH +: BASE_W] != 0) ovf_pending = 1'b1;
    acc_value = wide[CONV_WIDTH-1:0];
    if (digits_taken != '1) digits_taken++;
    if (fin) emit_number();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. The payload stays put while the block stalls. Valid is only
  // lowered for a gap, never in the same step as the next character is offered.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
    digit_char_i <= c;
    final_char_i <= fin;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (convert_char(c, fin)) chars_taken++;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], fin_last && (i == s.len() - 1));
  endtask

  // Random digits that are valid in the current input radix.
  task automatic send_digits(input int unsigned len, input logic fin_last);
    int unsigned radix;
    radix = 32'(clamp_radix(in_radix_reg));
    for (int unsigned i = 0; i < len; i++)
      send_char(ascii_of($urandom_range(radix - 1)), fin_last && (i == len - 1));
  endtask

  // Waits until every expected digit has come out and the block has settled.
  task automatic drain_outputs(input int unsigned tail);
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Both radix registers are written with the block idle.
  task automatic set_radices(input logic [BASE_W-1:0] in_b, input logic [BASE_W-1:0] out_b);
    drain_outputs(SETTLE_CYCLES);
    for (int i = 0; i < 2; i++) begin
      cfg_index_i <= (i == 0) ? CFG_INPUT_BASE : CFG_OUTPUT_BASE;
      cfg_data_i  <= (i == 0) ? in_b : out_b;
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i   <= 1'b0;
    in_radix_reg  = in_b;
    out_radix_reg = out_b;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall, or a long hold on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Each output transfer is compared against the oldest queued digit.
  always @(posedge clk_i) begin : digit_check
    out_digit_t got;
    out_digit_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{ch: out_char_o, eon: end_of_number_o, bad: bad_digit_o, ovf: overflowed_o};
      if (pending_digits.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected digit char %h eon %b bad %b ovf %b",
                 $time, got.ch, got.eon, got.bad, got.ovf);
      end else begin
        want = pending_digits.pop_front();
        digits_checked++;
        if (got !== want) begin
          fail_count++;
          $display("%0t: digit mismatch exp char %h eon %b bad %b ovf %b",
                   $time, want.ch, want.eon, want.bad, want.ovf);
          $display("%0t:                got char %h eon %b bad %b ovf %b",
                   $time, got.ch, got.eon, got.bad, got.ovf);
        end
        if (want.eon) begin
          numbers_checked++;
          bad_numbers += 32'(want.bad);
          ovf_numbers += 32'(want.ovf);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset radices (10 in, 10 out).
  task automatic test_decimal_cases();
    send_text("0", 1'b1);    // smallest value
    send_text("1a", 1'b0);   // lower case is invalid: "1" goes out flagged
    send_text("53", 1'b1);   // dropped, including the final mark
    send_char(8'h00, 1'b1);  // no digit at all: "0" flagged
    send_char(8'hFF, 1'b1);
    send_text("A", 1'b1);    // hex letter not below radix 10
  endtask

  task automatic test_hex_cases();
    set_radices(BASE_MAX, BASE_MIN);
    send_text("FFFFFFFF", 1'b1);   // all ones: 32 binary digits
    set_radices(BASE_MAX, BASE_MAX);
    send_text("FEDCBA987", 1'b1);  // ninth digit wraps the accumulator
    send_text("@", 1'b1);          // neighbors of the letter range
    send_text("G", 1'b1);
  endtask

  // One random sequence: mostly well-formed numbers, some broken, some noise.
  task automatic random_sequence();
    int unsigned radix;
    int unsigned pick;
    int unsigned len;
    logic fin;
    logic [CHAR_W-1:0] junk;
    radix = 32'(clamp_radix(in_radix_reg));
    pick = $urandom_range(99);
    if (pick < 75) begin
      // Now and then long enough to overflow the accumulator.
      if ($urandom_range(7) == 0) len = $urandom_range(1, full_length(radix) + 2);
      else len = $urandom_range(1, 4);
      send_digits(len, 1'b1);
    end else if (pick < 90) begin
      send_digits($urandom_range(3), 1'b0);
      do junk = CHAR_W'($urandom_range(255)); while (digit_weight(junk) < radix);
      fin = 1'($urandom_range(1));
      send_char(junk, fin);
      if (!fin) begin
        repeat ($urandom_range(2)) send_char(CHAR_W'($urandom_range(255)), 1'b0);
        send_char(CHAR_W'($urandom_range(255)), 1'b1);
      end
    end else begin
      send_char(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // Radix sweep including values below 2 and above 16. Three idling modes:
  // dense sender with a busy receiver, then the reverse, then no idling.
  task automatic test_random_traffic();
    int unsigned goal;
    logic [BASE_W-1:0] in_b;
    logic [BASE_W-1:0] out_b;
    for (int p = 0; p < SWEEP_PHASES; p++) begin
      in_b  = (p == SWEEP_PHASES - 1) ? BASE_W'($urandom_range(31)) : IN_SWEEP[p];
      out_b = (p == SWEEP_PHASES - 1) ? BASE_W'($urandom_range(31)) : OUT_SWEEP[p];
      set_radices(in_b, out_b);
      if (p < 3) begin
        send_gap_pct   = 9;
        recv_stall_pct = 84;
      end else if (p < 6) begin
        send_gap_pct   = 84;
        recv_stall_pct = 9;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      goal = chars_taken + PHASE_CHARS;
      while (chars_taken < goal) random_sequence();
    end
  endtask

  // The output is held for a long stretch while numbers keep coming, so the
  // block backs up and stalls its input.
  task automatic test_output_backpressure();
    set_radices(BASE_RESET, BASE_MAX);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    rx_hold_req    = LONG_HOLD;
    repeat (12) send_digits($urandom_range(1, 6), 1'b1);
  endtask

  initial begin : main_seq
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct   = 9;
    recv_stall_pct = 84;
    test_decimal_cases();
    test_hex_cases();
    test_random_traffic();
    test_output_backpressure();
    drain_outputs(TAIL_CYCLES);
    $display("%0d characters in, %0d digits checked over %0d numbers", chars_taken,
             digits_checked, numbers_checked);
    $display("%0d numbers stopped by a bad digit, %0d overflowed; radices swept 0..31",
             bad_numbers, ovf_numbers);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Several times the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d digits still expected", pending_digits.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
